[src/nearest_palette_color_search_defines.svh]
// Assertion macros shared by the checker of the nearest palette color search.
// Stand-alone header; the clock and reset are passed in by the user of each macro.
`ifndef NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH
`define NEAREST_PALETTE_COLOR_SEARCH_DEFINES_SVH

// Same-cycle implication, checked on every rising edge outside reset.
`define NPCS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every rising edge outside reset.
`define NPCS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[src/npcs_pkg.sv]
// Shared types and constants of the nearest palette color search.
// No dependencies; used by the top level, the distance unit and the checker.
`default_nettype none

package npcs_pkg;

  localparam int COLOR_W    = 8;
  localparam int INDEX_W    = 8;
  localparam int DIST_W     = 18;
  localparam int SIZE_W     = 9;
  localparam int ENTRY_W    = 3 * COLOR_W;
  localparam int SLOT_REACH = 256;

  typedef enum logic {
    CMD_LOAD  = 1'b0,
    CMD_QUERY = 1'b1
  } cmd_e;

  // Travels alongside each palette read through the scan pipeline.
  typedef struct packed {
    logic               vld;
    logic               last;
    logic [INDEX_W-1:0] idx;
  } scan_tag_t;

endpackage

`default_nettype wire

[src/nearest_palette_color_search.sv]
// Nearest palette color search: a load writes one palette entry; a query
// scans N = min(palette_size, PALETTE_DEPTH, 256) entries, one memory read per cycle.
// A query result is registered at the output once the scan ends and the output is free
// (an empty palette skips the scan); only then is the next item taken.
// Reset clears palette_size, the state, issue, output-valid and scan-tag registers;
// palette memory keeps its contents and is not cleared, entries are meaningful only once written.
`default_nettype none

module nearest_palette_color_search #(
  parameter int PALETTE_DEPTH = 256
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [npcs_pkg::SIZE_W-1:0]       cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_stall_o,
  input  wire logic                              cmd_i,
  input  wire logic [npcs_pkg::INDEX_W-1:0]      entry_index_i,
  input  wire logic [npcs_pkg::COLOR_W-1:0]      red_i,
  input  wire logic [npcs_pkg::COLOR_W-1:0]      green_i,
  input  wire logic [npcs_pkg::COLOR_W-1:0]      blue_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_stall_i,
  output logic                                   match_found_o,
  output logic      [npcs_pkg::INDEX_W-1:0]      best_index_o,
  output logic      [npcs_pkg::DIST_W-1:0]       best_distance_o
);
  import npcs_pkg::*;

  localparam int LIMIT = (PALETTE_DEPTH < SLOT_REACH) ? PALETTE_DEPTH : SLOT_REACH;
  localparam int AW    = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
  localparam int CW    = $clog2(LIMIT + 1);

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [SIZE_W-1:0]  size_q;
  logic [CW-1:0]      count_q, count_d, size_count;
  logic [CW-1:0]      rd_cnt_q, rd_cnt_d;
  logic               issue_q, issue_d;
  logic [COLOR_W-1:0] qr_q, qr_d, qg_q, qg_d, qb_q, qb_d;
  logic               found_q, found_d;
  logic [INDEX_W-1:0] best_idx_q, best_idx_d;
  logic [DIST_W-1:0]  best_dist_q, best_dist_d;
  logic               out_valid_q, out_valid_d;
  logic               out_found_q, out_found_d;
  logic [INDEX_W-1:0] out_idx_q, out_idx_d;
  logic [DIST_W-1:0]  out_dist_q, out_dist_d;

  logic               in_acc, wr_ok, mem_we, rd_en, rd_last;
  logic [AW-1:0]      wr_addr, rd_addr;
  logic [ENTRY_W-1:0] palette_mem [PALETTE_DEPTH];
  logic [ENTRY_W-1:0] mem_rdata_q;
  scan_tag_t          s1_tag_q, s1_tag_d, dist_tag;
  logic [DIST_W-1:0]  scan_dist;

  // Loads are taken only while idle and reads happen only during a scan, so the
  // state machine itself keeps a write and a read of one entry from overlapping.
  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = (state_q != ST_IDLE);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign wr_ok       = 32'(entry_index_i) < 32'(PALETTE_DEPTH);
  assign mem_we      = in_acc && (cmd_i == CMD_LOAD) && wr_ok;
  assign wr_addr     = AW'(entry_index_i);
  assign rd_en       = issue_q;
  assign rd_addr     = AW'(rd_cnt_q);
  assign rd_last     = (rd_cnt_q == count_q - CW'(1));
  assign size_count  = (size_q < SIZE_W'(LIMIT)) ? CW'(size_q) : CW'(LIMIT);

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      palette_mem[wr_addr] <= {red_i, green_i, blue_i};
    end
    if (rd_en) begin
      mem_rdata_q <= palette_mem[rd_addr];
    end
  end

  always_comb begin
    s1_tag_d.vld  = rd_en;
    s1_tag_d.last = rd_last;
    s1_tag_d.idx  = INDEX_W'(rd_cnt_q);
  end

  npcs_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .red_i   (qr_q),
    .green_i (qg_q),
    .blue_i  (qb_q),
    .entry_i (mem_rdata_q),
    .tag_i   (s1_tag_q),
    .tag_o   (dist_tag),
    .dist_o  (scan_dist)
  );

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    rd_cnt_d    = rd_cnt_q;
    issue_d     = issue_q;
    qr_d        = qr_q;
    qg_d        = qg_q;
    qb_d        = qb_q;
    found_d     = found_q;
    best_idx_d  = best_idx_q;
    best_dist_d = best_dist_q;
    out_valid_d = out_valid_q && out_stall_i;
    out_found_d = out_found_q;
    out_idx_d   = out_idx_q;
    out_dist_d  = out_dist_q;

    case (state_q)
      ST_IDLE: begin
        if (in_acc && (cmd_i == CMD_QUERY)) begin
          qr_d        = red_i;
          qg_d        = green_i;
          qb_d        = blue_i;
          count_d     = size_count;
          found_d     = (size_count != '0);
          best_idx_d  = '0;
          best_dist_d = '0;
          rd_cnt_d    = '0;
          if (size_count == '0) begin
            state_d = ST_DONE;
          end else begin
            state_d = ST_SCAN;
            issue_d = 1'b1;
          end
        end
      end
      ST_SCAN: begin
        if (issue_q) begin
          if (rd_last) begin
            issue_d = 1'b0;
          end else begin
            rd_cnt_d = rd_cnt_q + CW'(1);
          end
        end
        // Entry zero seeds the best; later entries replace it only when strictly closer.
        if (dist_tag.vld) begin
          if ((dist_tag.idx == '0) || (scan_dist < best_dist_q)) begin
            best_idx_d  = dist_tag.idx;
            best_dist_d = scan_dist;
          end
          if (dist_tag.last) begin
            state_d = ST_DONE;
          end
        end
      end
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_found_d = found_q;
          out_idx_d   = best_idx_q;
          out_dist_d  = best_dist_q;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
        issue_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      size_q      <= '0;
      issue_q     <= 1'b0;
      out_valid_q <= 1'b0;
      s1_tag_q    <= '0;
    end else begin
      state_q     <= state_d;
      issue_q     <= issue_d;
      out_valid_q <= out_valid_d;
      s1_tag_q    <= s1_tag_d;
      if (cfg_valid_i && cfg_ready_o) begin
        size_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    count_q     <= count_d;
    rd_cnt_q    <= rd_cnt_d;
    qr_q        <= qr_d;
    qg_q        <= qg_d;
    qb_q        <= qb_d;
    found_q     <= found_d;
    best_idx_q  <= best_idx_d;
    best_dist_q <= best_dist_d;
    out_found_q <= out_found_d;
    out_idx_q   <= out_idx_d;
    out_dist_q  <= out_dist_d;
  end

  assign out_valid_o     = out_valid_q;
  assign match_found_o   = out_found_q;
  assign best_index_o    = out_idx_q;
  assign best_distance_o = out_dist_q;

endmodule

`default_nettype wire

[src/npcs_dist.sv]
// Registered squared-distance unit: one palette entry against the query color.
// Depends on npcs_pkg for widths and the scan tag type.
`default_nettype none

module npcs_dist (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic [npcs_pkg::COLOR_W-1:0]    red_i,
  input  wire logic [npcs_pkg::COLOR_W-1:0]    green_i,
  input  wire logic [npcs_pkg::COLOR_W-1:0]    blue_i,
  input  wire logic [npcs_pkg::ENTRY_W-1:0]    entry_i,
  input  wire npcs_pkg::scan_tag_t             tag_i,
  output npcs_pkg::scan_tag_t                  tag_o,
  output logic      [npcs_pkg::DIST_W-1:0]     dist_o
);
  import npcs_pkg::*;

  logic [COLOR_W-1:0]   e_red, e_green, e_blue;
  logic [COLOR_W-1:0]   d_red, d_green, d_blue;
  logic [2*COLOR_W-1:0] sq_red, sq_green, sq_blue;
  logic [DIST_W-1:0]    dist_d, dist_q;
  scan_tag_t            tag_q;

  assign e_red   = entry_i[3*COLOR_W-1:2*COLOR_W];
  assign e_green = entry_i[2*COLOR_W-1:COLOR_W];
  assign e_blue  = entry_i[COLOR_W-1:0];

  always_comb begin
    d_red    = (red_i   >= e_red)   ? (red_i - e_red)     : (e_red - red_i);
    d_green  = (green_i >= e_green) ? (green_i - e_green) : (e_green - green_i);
    d_blue   = (blue_i  >= e_blue)  ? (blue_i - e_blue)   : (e_blue - blue_i);
    sq_red   = d_red * d_red;
    sq_green = d_green * d_green;
    sq_blue  = d_blue * d_blue;
    dist_d   = DIST_W'(sq_red) + DIST_W'(sq_green) + DIST_W'(sq_blue);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag_q <= '0;
    end else begin
      tag_q <= tag_i;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign tag_o  = tag_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

[src/npcs_checker.sv]
// Port-level checker for the nearest palette color search, bound to the top level.
// Depends on npcs_pkg and the assertion macros in nearest_palette_color_search_defines.svh.
`default_nettype none

`include "nearest_palette_color_search_defines.svh"

module npcs_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          in_valid_i,
  input wire logic                          in_stall_o,
  input wire logic                          cmd_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_stall_i,
  input wire logic                          match_found_o,
  input wire logic [npcs_pkg::INDEX_W-1:0]  best_index_o,
  input wire logic [npcs_pkg::DIST_W-1:0]   best_distance_o
);
  import npcs_pkg::*;

  logic query_acc;

  assign query_acc = in_valid_i && !in_stall_o && (cmd_i == CMD_QUERY);

  `NPCS_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_o && out_stall_i, out_valid_o, "result item dropped while stalled")
  `NPCS_ASSERT_NEXT(a_out_stable, clk_i, rst_ni, out_valid_o && out_stall_i, $stable(best_distance_o) && $stable(best_index_o) && $stable(match_found_o), "stalled result item changed")
  `NPCS_ASSERT_NOW(a_empty_zero, clk_i, rst_ni, out_valid_o && !match_found_o, (best_index_o == '0) && (best_distance_o == '0), "empty palette result not zero")
  `NPCS_ASSERT_NEXT(a_query_busy, clk_i, rst_ni, query_acc, in_stall_o, "input taken while a query is in progress")

endmodule

bind nearest_palette_color_search npcs_checker u_npcs_checker (.*);

`default_nettype wire
